[rtl/mce_pkg.sv]
// Shared types, constants and helper functions for the Mandelbrot column
// escape-time block. Used by the serial divider and by the top level.
// No dependencies.
package mce_pkg;

  // Pixels in one strip, and the bits of a pixel position.
  localparam int STRIP_LEN = 64;
  localparam int PIX_W     = $clog2(STRIP_LEN);

  // Coordinate and datapath widths.
  localparam int COORD_W = 32;
  localparam int DELTA_W = COORD_W - PIX_W;
  localparam int SUB_W   = 8;
  localparam int COL_W   = SUB_W + PIX_W;
  localparam int ITER_W  = 10;
  localparam int GAIN_W  = 8;
  localparam int HUE_W   = 8;
  localparam int HPROD_W = ITER_W + GAIN_W;
  localparam int PROD_W  = 2 * COORD_W;

  // Serial divider: dividend width and step counter width.
  localparam int DIV_W     = DELTA_W + COL_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Escape bound: |z|^2 > 10 in Q8.56.
  localparam logic [PROD_W-1:0] ESC_BOUND = PROD_W'(10) << 56;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [SUB_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [SUB_W-1:0] remainder;
  } div_rsp_t;

  // Clamp a signed value to the signed 32-bit range.
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(64'sh0000_0000_7FFF_FFFF);
    lo = -PROD_W'(64'sh0000_0000_8000_0000);
    if (x > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      return 32'sh8000_0000;
    end else begin
      return x[COORD_W-1:0];
    end
  endfunction

  // Residue modulo 255 by folding bytes, since 256 is one more than 255.
  function automatic logic [HUE_W-1:0] mod255(input logic [HPROD_W-1:0] x);
    logic [10:0] s1;
    logic [8:0]  s2;
    s1 = 11'(x[HPROD_W-1:8]) + 11'(x[7:0]);
    s2 = 9'(s1[10:8]) + 9'(s1[7:0]);
    if (s2 >= 9'd255) begin
      s2 = s2 - 9'd255;
    end
    return s2[HUE_W-1:0];
  endfunction

endpackage

[rtl/mce_div.sv]
// Restoring serial divider: one quotient bit per cycle, unsigned dividend
// by a narrow unsigned divisor. Depends on mce_pkg for widths and structs.
module mce_div
  import mce_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     quo_r;
  logic [SUB_W-1:0]     rem_r;
  logic [SUB_W-1:0]     dvs_r;

  logic [SUB_W:0]       trial;
  logic                 fits;

  // Bring down the next dividend bit and try a subtraction.
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], fits};
      rem_r <= fits ? SUB_W'(trial - {1'b0, dvs_r}) : trial[SUB_W-1:0];
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

[rtl/mandelbrot_column_escape_time_top.sv]
// Mandelbrot column escape-time block: one tick beat in, 64 pixel beats out.
// Column setup runs two divides and one multiply, then each pixel iterates at
// most iteration_limit times. A new tick is taken only once the last pixel of
// the previous one is emitted, and an output stall holds the sequencer. Each
// iteration runs MUL_RR, MUL_II and MUL_RI on the shared 32x32 multiplier, then UPDATE.
// Synchronous active-low reset clears control state and loads the register defaults.
module mandelbrot_column_escape_time_top
  import mce_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  // Tick channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [31:0]         in_tick_count,

  // Pixel channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PIX_W-1:0]    out_pixel_index,
  output logic [ITER_W-1:0]   out_escape_count,
  output logic [HUE_W-1:0]    out_hue_index,
  output logic                out_inside_set,
  output logic                out_last_pixel,

  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Register map: index i sits at byte address 4*i.
  localparam logic [2:0] REG_RE_START = 3'd0;
  localparam logic [2:0] REG_IM_LOW   = 3'd1;
  localparam logic [2:0] REG_IM_HIGH  = 3'd2;
  localparam logic [2:0] REG_COL_SUB  = 3'd3;
  localparam logic [2:0] REG_ITER_LIM = 3'd4;
  localparam logic [2:0] REG_HUE_GAIN = 3'd5;

  // The sequencer. Column setup runs DIV_COL, MUL_COL and DIV_CRE once per
  // tick; each pixel then loops MUL_RR, MUL_II, MUL_RI, UPDATE until it
  // escapes or hits the limit, and finishes through HUE and EMIT.
  typedef enum logic [10:0] {
    ST_IDLE     = 11'b000_0000_0001,
    ST_DIV_COL  = 11'b000_0000_0010,
    ST_MUL_COL  = 11'b000_0000_0100,
    ST_DIV_CRE  = 11'b000_0000_1000,
    ST_PIX_INIT = 11'b000_0001_0000,
    ST_MUL_RR   = 11'b000_0010_0000,
    ST_MUL_II   = 11'b000_0100_0000,
    ST_MUL_RI   = 11'b000_1000_0000,
    ST_UPDATE   = 11'b001_0000_0000,
    ST_HUE      = 11'b010_0000_0000,
    ST_EMIT     = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic signed [COORD_W-1:0] re_start_r;
  logic signed [COORD_W-1:0] im_low_r;
  logic signed [COORD_W-1:0] im_high_r;
  logic [SUB_W-1:0]          col_sub_r;
  logic [ITER_W-1:0]         iter_limit_r;
  logic [GAIN_W-1:0]         hue_gain_r;

  // Per-tick and per-pixel working state.
  logic [PIX_W-1:0]          tick_lo_r;
  logic [DELTA_W-1:0]        delta_r;
  logic [COL_W-1:0]          col_r;
  logic signed [COORD_W-1:0] cre_r;
  logic signed [COORD_W+1:0] cim_acc_r;
  logic signed [COORD_W-1:0] cim_r;
  logic signed [COORD_W-1:0] zre_r;
  logic signed [COORD_W-1:0] zim_r;
  logic [PROD_W-1:0]         sq_re_r;
  logic [PROD_W-1:0]         sq_im_r;
  logic signed [PROD_W-1:0]  cross_r;
  logic signed [PROD_W-1:0]  diff_r;
  logic [ITER_W-1:0]         itn_r;
  logic [ITER_W-1:0]         count_r;
  logic                      inside_r;
  logic [HPROD_W-1:0]        hue_prod_r;
  logic [PIX_W-1:0]          pix_r;
  logic                      out_valid_r;

  logic                      in_accept;
  logic                      out_free;
  logic                      cfg_write;
  logic [2:0]                cfg_idx;
  logic [SUB_W-1:0]          sub_eff;
  logic signed [COORD_W:0]   im_span;
  logic [COORD_W:0]          im_span_abs;
  logic [PROD_W-1:0]         mag;
  logic                      escaped;
  logic                      at_limit;
  logic                      last_pix;

  logic signed [COORD_W-1:0] mul_a;
  logic signed [COORD_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  // The output register can take a new pixel when empty or being drained.
  assign out_free  = !out_valid_r || !out_stall;
  assign last_pix  = (pix_r == PIX_W'(STRIP_LEN - 1));

  // ---------------------------------------------------------------------
  // Configuration port. Writes land on the access phase; reads are a
  // plain mux of the register file, narrow registers zero-extended.
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      re_start_r   <= -32'sd536870912;
      im_low_r     <= -32'sd335544320;
      im_high_r    <= 32'sd335544320;
      col_sub_r    <= SUB_W'(1);
      iter_limit_r <= ITER_W'(64);
      hue_gain_r   <= GAIN_W'(1);
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_RE_START: re_start_r   <= pwdata;
        REG_IM_LOW:   im_low_r     <= pwdata;
        REG_IM_HIGH:  im_high_r    <= pwdata;
        REG_COL_SUB:  col_sub_r    <= pwdata[SUB_W-1:0];
        REG_ITER_LIM: iter_limit_r <= pwdata[ITER_W-1:0];
        REG_HUE_GAIN: hue_gain_r   <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_RE_START: prdata = re_start_r;
      REG_IM_LOW:   prdata = im_low_r;
      REG_IM_HIGH:  prdata = im_high_r;
      REG_COL_SUB:  prdata = 32'(col_sub_r);
      REG_ITER_LIM: prdata = 32'(iter_limit_r);
      REG_HUE_GAIN: prdata = 32'(hue_gain_r);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Column setup arithmetic. A subdivision of zero behaves as one. The
  // pixel spacing is the absolute imaginary span over the strip length,
  // which for a power-of-two strip is a plain shift.
  // ---------------------------------------------------------------------
  assign sub_eff     = (col_sub_r == '0) ? SUB_W'(1) : col_sub_r;
  assign im_span     = {im_high_r[COORD_W-1], im_high_r} - {im_low_r[COORD_W-1], im_low_r};
  assign im_span_abs = im_span[COORD_W] ? (COORD_W+1)'(-im_span) : im_span;

  // ---------------------------------------------------------------------
  // The shared multiplier. Operands follow the sequencer state: the column
  // product delta*j, the three products of z, and the hue product.
  // ---------------------------------------------------------------------
  always_comb begin
    case (state_r)
      ST_MUL_COL: begin
        mul_a = $signed(COORD_W'(delta_r));
        mul_b = $signed(COORD_W'(col_r));
      end
      ST_MUL_RR: begin
        mul_a = zre_r;
        mul_b = zre_r;
      end
      ST_MUL_II: begin
        mul_a = zim_r;
        mul_b = zim_r;
      end
      ST_MUL_RI: begin
        mul_a = zre_r;
        mul_b = zim_r;
      end
      ST_HUE: begin
        mul_a = $signed(COORD_W'(count_r));
        mul_b = $signed(COORD_W'(hue_gain_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // ---------------------------------------------------------------------
  // The serial divider serves twice per tick. First it reduces the tick
  // (without its low pixel bits) modulo the subdivision, which gives the
  // column; then it divides delta*column by the subdivision for the real
  // offset of the column.
  // ---------------------------------------------------------------------
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(in_tick_count[31:PIX_W]);
    div_req.divisor  = sub_eff;
    if (state_r == ST_IDLE) begin
      div_req.start = in_accept;
    end else if (state_r == ST_MUL_COL) begin
      div_req.start    = 1'b1;
      div_req.dividend = mul_p[DIV_W-1:0];
    end
  end

  mce_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Escape test on the squares of the freshly updated z. Before the first
  // update z is zero and never escapes, which the iteration count guards.
  assign mag      = sq_re_r + sq_im_r;
  assign escaped  = (itn_r != '0) && (mag > ESC_BOUND);
  assign at_limit = (itn_r == iter_limit_r);

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_accept) state_nxt = ST_DIV_COL;
      ST_DIV_COL:  if (div_rsp.done) state_nxt = ST_MUL_COL;
      ST_MUL_COL:  state_nxt = ST_DIV_CRE;
      ST_DIV_CRE:  if (div_rsp.done) state_nxt = ST_PIX_INIT;
      ST_PIX_INIT: state_nxt = ST_MUL_RR;
      ST_MUL_RR:   state_nxt = ST_MUL_II;
      ST_MUL_II:   state_nxt = ST_MUL_RI;
      ST_MUL_RI:   state_nxt = (escaped || at_limit) ? ST_HUE : ST_UPDATE;
      ST_UPDATE:   state_nxt = ST_MUL_RR;
      ST_HUE:      state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = last_pix ? ST_IDLE : ST_PIX_INIT;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (out_valid_r && out_stall) || (state_r == ST_EMIT && out_free);
    end
  end

  // Datapath registers; none of them needs a reset value.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        tick_lo_r <= in_tick_count[PIX_W-1:0];
        delta_r   <= im_span_abs[COORD_W-1:PIX_W];
        cim_acc_r <= {{2{im_low_r[COORD_W-1]}}, im_low_r};
        pix_r     <= '0;
      end
      ST_DIV_COL: begin
        col_r <= {div_rsp.remainder, tick_lo_r};
      end
      ST_DIV_CRE: begin
        cre_r <= sat32({{(PROD_W-COORD_W){re_start_r[COORD_W-1]}}, re_start_r}
                       + $signed(PROD_W'(div_rsp.quotient)));
      end
      ST_PIX_INIT: begin
        cim_r <= sat32({{(PROD_W-COORD_W-2){cim_acc_r[COORD_W+1]}}, cim_acc_r});
        zre_r <= '0;
        zim_r <= '0;
        itn_r <= '0;
      end
      ST_MUL_RR: begin
        sq_re_r <= mul_p;
      end
      ST_MUL_II: begin
        sq_im_r <= mul_p;
      end
      ST_MUL_RI: begin
        cross_r <= mul_p;
        diff_r  <= $signed(sq_re_r) - $signed(sq_im_r);
        if (escaped) begin
          count_r  <= itn_r - 1'b1;
          inside_r <= 1'b0;
        end else begin
          count_r  <= iter_limit_r;
          inside_r <= 1'b1;
        end
      end
      ST_UPDATE: begin
        // Real part takes the floor of the square difference in Q4.28; the
        // imaginary part doubles the cross product by shifting one less.
        // Both addends stay signed so that the shifts remain arithmetic.
        zre_r <= sat32((diff_r >>> 28)
                       + $signed({{(PROD_W-COORD_W){cre_r[COORD_W-1]}}, cre_r}));
        zim_r <= sat32((cross_r >>> 27)
                       + $signed({{(PROD_W-COORD_W){cim_r[COORD_W-1]}}, cim_r}));
        itn_r <= itn_r + 1'b1;
      end
      ST_HUE: begin
        hue_prod_r <= mul_p[HPROD_W-1:0];
      end
      ST_EMIT: begin
        if (out_free) begin
          out_pixel_index  <= pix_r;
          out_escape_count <= count_r;
          out_hue_index    <= inside_r ? '0 : mod255(hue_prod_r);
          out_inside_set   <= inside_r;
          out_last_pixel   <= last_pix;
          pix_r            <= pix_r + 1'b1;
          cim_acc_r        <= cim_acc_r + $signed((COORD_W+2)'(delta_r));
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------

  // A pixel beat is only ever launched from the emit step.
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_EMIT))
    else $error("pixel beat appeared outside the emit step");

  // An update never runs past the iteration limit.
  a_itn_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |-> (itn_r < iter_limit_r))
    else $error("iteration ran past the limit");

  // An escaped pixel reports a count below the limit.
  a_escape_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_inside_set) |-> (out_escape_count < iter_limit_r))
    else $error("escaped pixel with count at or above the limit");

  // An inside pixel is black and reports the limit as its count.
  a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_inside_set) |->
      (out_hue_index == '0 && out_escape_count == iter_limit_r))
    else $error("inside pixel with a hue or a wrong count");

endmodule
